// ===== rtl/i2c_master_bit_engine_assert.svh =====
// assertion macros for the i2c master bit engine
// used by rtl modules that check their own sequencing; expects clk and rst_n in scope
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// condition and consequence in the same cycle
`define I2C_MBE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c_mbe same-cycle check failed");

// consequence holds in the cycle after the condition
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c_mbe next-cycle check failed");

`else

`define I2C_MBE_ASSERT_NOW(lbl, ante, cons)
`define I2C_MBE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/i2c_mbe_pkg.sv =====
// types and constants shared by the i2c master bit engine
// no dependencies
`timescale 1ns / 1ps

package i2c_mbe_pkg;

  // command codes carried in the opcode field
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_WACK  = 3'd4;
  localparam logic [2:0] OP_READ  = 3'd5;

  // configuration register indexes
  localparam logic CFG_TICKS_PER_US = 1'b0;
  localparam logic CFG_ACK_TIMEOUT  = 1'b1;

  localparam int unsigned TPU_W   = 10;
  localparam int unsigned DELAY_W = 14;

  localparam logic [TPU_W-1:0] TPU_RESET     = 10'd1;
  localparam logic [7:0]       TIMEOUT_RESET = 8'd250;

  // sequencer phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE  = 6'b000001,
    PH_START = 6'b000010,
    PH_STOP  = 6'b000100,
    PH_SEND  = 6'b001000,
    PH_WACK  = 6'b010000,
    PH_READ  = 6'b100000
  } phase_t;

  // one tick of input
  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  // line and status after one tick
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } res_t;

  // command code to the phase that runs it
  function automatic phase_t op_to_phase(input logic [2:0] op);
    phase_t ph;
    case (op)
      OP_START: ph = PH_START;
      OP_STOP:  ph = PH_STOP;
      OP_SEND:  ph = PH_SEND;
      OP_WACK:  ph = PH_WACK;
      OP_READ:  ph = PH_READ;
      default:  ph = PH_IDLE;
    endcase
    return ph;
  endfunction

endpackage

// ===== rtl/i2c_mbe_in_if.sv =====
// input channel of the i2c master bit engine: one tick per transaction
// no dependencies
`timescale 1ns / 1ps

interface i2c_mbe_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, output opcode, output tx_byte, output send_ack,
                  output sda_in, input ready);
  modport sink (input valid, input opcode, input tx_byte, input send_ack,
                input sda_in, output ready);
endinterface

// ===== rtl/i2c_mbe_out_if.sv =====
// result channel of the i2c master bit engine: line state per transaction
// no dependencies
`timescale 1ns / 1ps

interface i2c_mbe_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_enable;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_failed;

  modport source (output valid, output scl_level, output sda_level, output sda_enable,
                  output busy_res, output done_res, output rx_byte, output ack_failed,
                  input ready);
  modport sink (input valid, input scl_level, input sda_level, input sda_enable,
                input busy_res, input done_res, input rx_byte, input ack_failed,
                output ready);
endinterface

// ===== rtl/i2c_master_bit_engine.sv =====
// I2C master bit engine. Each input transaction is one tick of the bus sequencer and
// yields one result transaction with the SCL/SDA drive and status after that tick.
// One transaction is taken every cycle unless the result channel stalls; a result passes
// through the input register and the step logic into the result register; the step logic
// advances the sequencer exactly once per tick. Commands arriving while busy are ignored.
// Depends on i2c_mbe_pkg, i2c_mbe_in_if, i2c_mbe_out_if and i2c_mbe_core.
`timescale 1ns / 1ps

module i2c_master_bit_engine
  import i2c_mbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  i2c_mbe_in_if.sink     in_ch,
  i2c_mbe_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_wdata
);

  logic             s1_valid_r, s1_valid_nxt;
  item_t            s1_item_r;
  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;
  res_t             step_res;
  logic             in_acc;
  logic             advance;
  logic [TPU_W-1:0] tpu_r;
  logic [7:0]       timeout_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tpu_r     <= TPU_RESET;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TICKS_PER_US: tpu_r     <= cfg_wdata[TPU_W-1:0];
        CFG_ACK_TIMEOUT:  timeout_r <= cfg_wdata[7:0];
        default:          tpu_r     <= tpu_r;
      endcase
    end
  end

  // handshake between input register and result register
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_acc ? 1'b1 : (advance ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = advance ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.opcode   <= in_ch.opcode;
      s1_item_r.tx_byte  <= in_ch.tx_byte;
      s1_item_r.send_ack <= in_ch.send_ack;
      s1_item_r.sda_in   <= in_ch.sda_in;
    end
    if (advance) begin
      out_res_r <= step_res;
    end
  end

  // sequencer step
  i2c_mbe_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .item         (s1_item_r),
    .ticks_per_us (tpu_r),
    .ack_timeout  (timeout_r),
    .res          (step_res)
  );

  // result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.scl_level  = out_res_r.scl_level;
  assign out_ch.sda_level  = out_res_r.sda_level;
  assign out_ch.sda_enable = out_res_r.sda_enable;
  assign out_ch.busy_res   = out_res_r.busy_res;
  assign out_ch.done_res   = out_res_r.done_res;
  assign out_ch.rx_byte    = out_res_r.rx_byte;
  assign out_ch.ack_failed = out_res_r.ack_failed;

endmodule

// ===== rtl/i2c_mbe_core.sv =====
// sequencer state and one-tick step logic of the i2c master bit engine
// depends on i2c_mbe_pkg and i2c_master_bit_engine_assert.svh
`timescale 1ns / 1ps
`include "i2c_master_bit_engine_assert.svh"

module i2c_mbe_core
  import i2c_mbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  item_t            item,
  input  logic [TPU_W-1:0] ticks_per_us,
  input  logic [7:0]       ack_timeout,
  output res_t             res
);

  phase_t             phase_r, phase_nxt;
  logic [2:0]         sub_r, sub_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [7:0]         poll_r, poll_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               sda_en_r, sda_en_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               fail_r, fail_nxt;
  logic               ack_r, ack_nxt;
  logic               done;
  logic               run;

  logic [TPU_W-1:0]   tpu_eff;
  logic [DELAY_W-1:0] hold1, hold2, hold4, hold10;

  // delay loads for 1, 2, 4 and 10 microseconds, minus the step tick itself
  assign tpu_eff = (ticks_per_us == '0) ? TPU_W'(1) : ticks_per_us;
  assign hold1   = {4'b0, tpu_eff} - DELAY_W'(1);
  assign hold2   = {3'b0, tpu_eff, 1'b0} - DELAY_W'(1);
  assign hold4   = {2'b0, tpu_eff, 2'b0} - DELAY_W'(1);
  assign hold10  = ({1'b0, tpu_eff, 3'b0} + {3'b0, tpu_eff, 1'b0}) - DELAY_W'(1);

  // next state for one tick
  always_comb begin
    phase_nxt  = phase_r;
    sub_nxt    = sub_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    delay_nxt  = delay_r;
    poll_nxt   = poll_r;
    scl_nxt    = scl_r;
    sda_nxt    = sda_r;
    sda_en_nxt = sda_en_r;
    rx_nxt     = rx_r;
    fail_nxt   = fail_r;
    ack_nxt    = ack_r;
    done       = 1'b0;
    run        = 1'b0;

    // accept a command, count a delay, or run the next step
    if (phase_r == PH_IDLE) begin
      if ((item.opcode >= OP_START) && (item.opcode <= OP_READ)) begin
        run       = 1'b1;
        phase_nxt = op_to_phase(item.opcode);
        sub_nxt   = 3'd0;
        delay_nxt = '0;
        if (item.opcode == OP_SEND) shift_nxt = item.tx_byte;
        if (item.opcode == OP_READ) ack_nxt = item.send_ack;
      end
    end else if (delay_r != '0) begin
      delay_nxt = delay_r - DELAY_W'(1);
    end else begin
      run = 1'b1;
    end

    if (run) begin
      case (phase_nxt)
        PH_START: begin
          case (sub_nxt)
            3'd0: begin
              sda_en_nxt = 1'b1; sda_nxt = 1'b1; delay_nxt = hold1; sub_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt = 1'b1; delay_nxt = hold4; sub_nxt = 3'd2;
            end
            3'd2: begin
              sda_nxt = 1'b0; delay_nxt = hold4; sub_nxt = 3'd3;
            end
            default: begin
              scl_nxt = 1'b0;
              phase_nxt = PH_IDLE; sub_nxt = 3'd0; delay_nxt = '0; done = 1'b1;
            end
          endcase
        end
        PH_STOP: begin
          case (sub_nxt)
            3'd0: begin
              scl_nxt = 1'b0; sda_en_nxt = 1'b1; sda_nxt = 1'b0;
              delay_nxt = '0; sub_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt = 1'b1; delay_nxt = hold4; sub_nxt = 3'd2;
            end
            3'd2: begin
              sda_nxt = 1'b1; delay_nxt = hold4; sub_nxt = 3'd3;
            end
            default: begin
              phase_nxt = PH_IDLE; sub_nxt = 3'd0; delay_nxt = '0; done = 1'b1;
            end
          endcase
        end
        PH_SEND: begin
          case (sub_nxt)
            3'd0: begin
              sda_en_nxt = 1'b1; scl_nxt = 1'b0; bit_nxt = 4'd0;
              delay_nxt = hold10; sub_nxt = 3'd1;
            end
            // msb onto the data line while the clock is low
            3'd1: begin
              sda_nxt   = shift_nxt[7];
              shift_nxt = {shift_nxt[6:0], 1'b0};
              delay_nxt = hold4; sub_nxt = 3'd2;
            end
            3'd2: begin
              scl_nxt = 1'b1; delay_nxt = hold4; sub_nxt = 3'd3;
            end
            3'd3: begin
              scl_nxt   = 1'b0; delay_nxt = hold4;
              bit_nxt   = bit_r + 4'd1;
              sub_nxt   = bit_nxt[3] ? 3'd4 : 3'd1;
            end
            default: begin
              phase_nxt = PH_IDLE; sub_nxt = 3'd0; delay_nxt = '0; done = 1'b1;
            end
          endcase
        end
        PH_WACK: begin
          case (sub_nxt)
            3'd0: begin
              sda_en_nxt = 1'b0; scl_nxt = 1'b1; delay_nxt = hold1; sub_nxt = 3'd1;
            end
            3'd1: begin
              sda_en_nxt = 1'b0; sda_nxt = 1'b1; poll_nxt = 8'd0;
              delay_nxt = hold1; sub_nxt = 3'd2;
            end
            // poll once per tick; on timeout fall into the stop sequence
            3'd2: begin
              if (!item.sda_in) begin
                delay_nxt = hold1; sub_nxt = 3'd3;
              end else if (poll_r == ack_timeout) begin
                fail_nxt  = 1'b1;
                phase_nxt = PH_STOP; sub_nxt = 3'd0; delay_nxt = '0;
              end else begin
                poll_nxt  = poll_r + 8'd1;
                delay_nxt = '0;
              end
            end
            3'd3: begin
              scl_nxt = 1'b0; sda_en_nxt = 1'b1; sda_nxt = 1'b0; fail_nxt = 1'b0;
              delay_nxt = hold1; sub_nxt = 3'd4;
            end
            default: begin
              phase_nxt = PH_IDLE; sub_nxt = 3'd0; delay_nxt = '0; done = 1'b1;
            end
          endcase
        end
        PH_READ: begin
          case (sub_nxt)
            3'd0: begin
              sda_en_nxt = 1'b0; sda_nxt = 1'b1; scl_nxt = 1'b0;
              bit_nxt = 4'd0; shift_nxt = 8'd0; delay_nxt = '0; sub_nxt = 3'd1;
            end
            3'd1: begin
              scl_nxt = 1'b0; delay_nxt = hold2; sub_nxt = 3'd2;
            end
            // sample data on the clock rise
            3'd2: begin
              scl_nxt   = 1'b1;
              shift_nxt = {shift_r[6:0], item.sda_in};
              bit_nxt   = bit_r + 4'd1;
              delay_nxt = hold1;
              sub_nxt   = bit_nxt[3] ? 3'd3 : 3'd1;
            end
            3'd3: begin
              rx_nxt  = shift_r;
              scl_nxt = 1'b0; sda_en_nxt = 1'b1; sda_nxt = !ack_r;
              delay_nxt = hold2; sub_nxt = 3'd4;
            end
            3'd4: begin
              scl_nxt = 1'b1; delay_nxt = hold2; sub_nxt = 3'd5;
            end
            default: begin
              scl_nxt = 1'b0;
              phase_nxt = PH_IDLE; sub_nxt = 3'd0; delay_nxt = '0; done = 1'b1;
            end
          endcase
        end
        default: begin
          phase_nxt = PH_IDLE; sub_nxt = 3'd0; delay_nxt = '0; done = 1'b1;
        end
      endcase
    end
  end

  // state registers advance once per accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      sub_r    <= 3'd0;
      bit_r    <= 4'd0;
      shift_r  <= 8'd0;
      delay_r  <= '0;
      poll_r   <= 8'd0;
      scl_r    <= 1'b1;
      sda_r    <= 1'b1;
      sda_en_r <= 1'b0;
      rx_r     <= 8'd0;
      fail_r   <= 1'b0;
      ack_r    <= 1'b0;
    end else if (step_en) begin
      phase_r  <= phase_nxt;
      sub_r    <= sub_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      delay_r  <= delay_nxt;
      poll_r   <= poll_nxt;
      scl_r    <= scl_nxt;
      sda_r    <= sda_nxt;
      sda_en_r <= sda_en_nxt;
      rx_r     <= rx_nxt;
      fail_r   <= fail_nxt;
      ack_r    <= ack_nxt;
    end
  end

  // result of this tick, from the state it leaves
  always_comb begin
    res.scl_level  = scl_nxt;
    res.sda_level  = sda_nxt;
    res.sda_enable = sda_en_nxt;
    res.busy_res   = (phase_nxt != PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.ack_failed = fail_nxt;
  end

  // lines hold while a delay counts down
  `I2C_MBE_ASSERT_NEXT(a_lines_hold, step_en && (phase_r != PH_IDLE) && (delay_r != '0), $stable(scl_r) && $stable(sda_r) && $stable(sda_en_r))
  // nothing moves without a tick
  `I2C_MBE_ASSERT_NEXT(a_no_tick_no_move, !step_en, $stable(phase_r) && $stable(delay_r) && $stable(sub_r))
  // failure flag only rises out of wait-ack
  `I2C_MBE_ASSERT_NEXT(a_fail_from_wack, step_en && !fail_r && (phase_r != PH_WACK), !fail_r)
  // an idle sequencer carries no pending delay
  `I2C_MBE_ASSERT_NOW(a_idle_no_delay, phase_r == PH_IDLE, delay_r == '0)

endmodule

// ===== bench/i2c_master_bit_engine_tb.sv =====
// self-checking bench for the i2c master bit engine: directed command sequences,
// then random bus transactions checked tick by tick against a behavioral line model
// depends on i2c_mbe_pkg, i2c_mbe_in_if, i2c_mbe_out_if and i2c_master_bit_engine
`timescale 1ns / 1ps

module i2c_master_bit_engine_tb;
  import i2c_mbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int          MAX_PRINTED = 100;

  // opcodes the engine treats as no command
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  // how sda_in is driven while a command runs
  localparam int SDA_LOW    = 0;
  localparam int SDA_HIGH   = 1;
  localparam int SDA_RANDOM = 2;

  // ack_wait long enough that the slave never answers
  localparam int NO_ACK = 100000;

  logic clk = 1'b0;
  logic rst_n;
  logic       cfg_we;
  logic       cfg_index;
  logic [9:0] cfg_wdata;

  i2c_mbe_in_if  in_ch ();
  i2c_mbe_out_if out_ch ();

  i2c_master_bit_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          ticks_sent = 0;

  // line model: configuration
  logic [9:0] tick_scale = TPU_RESET;
  logic [7:0] poll_limit = TIMEOUT_RESET;

  // line model: sequencer state
  phase_t      bus_phase  = PH_IDLE;
  logic [2:0]  bus_sub    = '0;
  logic [3:0]  bus_bit    = '0;
  logic [7:0]  bus_shift  = '0;
  logic [13:0] bus_delay  = '0;
  logic [7:0]  bus_polls  = '0;
  logic        bus_scl    = 1'b1;
  logic        bus_sda    = 1'b1;
  logic        bus_sda_en = 1'b0;
  logic [7:0]  bus_rx     = '0;
  logic        bus_fail   = 1'b0;
  logic        bus_ack    = 1'b0;
  logic        bus_done   = 1'b0;

  res_t expected_lines[$];

  // delay counter load for a hold of some microseconds
  function automatic logic [13:0] hold_ticks(input int unsigned us);
    int unsigned t;
    t = (tick_scale == 10'd0) ? 1 : tick_scale;
    t = t * us;
    return (t == 0) ? 14'd0 : 14'(t - 1);
  endfunction

  function automatic void end_command();
    bus_phase = PH_IDLE;
    bus_sub   = '0;
    bus_delay = '0;
    bus_done  = 1'b1;
  endfunction

  // run the next step of the active command
  function automatic void advance_step(input logic sda_in);
    case (bus_phase)
      PH_START: begin
        case (bus_sub)
          3'd0: begin bus_sda_en = 1'b1; bus_sda = 1'b1; bus_delay = hold_ticks(1); bus_sub = 3'd1; end
          3'd1: begin bus_scl = 1'b1; bus_delay = hold_ticks(4); bus_sub = 3'd2; end
          3'd2: begin bus_sda = 1'b0; bus_delay = hold_ticks(4); bus_sub = 3'd3; end
          default: begin bus_scl = 1'b0; end_command(); end
        endcase
      end
      PH_STOP: begin
        case (bus_sub)
          3'd0: begin
            bus_scl = 1'b0; bus_sda_en = 1'b1; bus_sda = 1'b0;
            bus_delay = hold_ticks(0); bus_sub = 3'd1;
          end
          3'd1: begin bus_scl = 1'b1; bus_delay = hold_ticks(4); bus_sub = 3'd2; end
          3'd2: begin bus_sda = 1'b1; bus_delay = hold_ticks(4); bus_sub = 3'd3; end
          default: end_command();
        endcase
      end
      PH_SEND: begin
        case (bus_sub)
          3'd0: begin
            bus_sda_en = 1'b1; bus_scl = 1'b0; bus_bit = '0;
            bus_delay = hold_ticks(10); bus_sub = 3'd1;
          end
          3'd1: begin
            bus_sda   = bus_shift[7];
            bus_shift = {bus_shift[6:0], 1'b0};
            bus_delay = hold_ticks(4); bus_sub = 3'd2;
          end
          3'd2: begin bus_scl = 1'b1; bus_delay = hold_ticks(4); bus_sub = 3'd3; end
          3'd3: begin
            bus_scl = 1'b0; bus_delay = hold_ticks(4);
            bus_bit = bus_bit + 4'd1;
            bus_sub = (bus_bit >= 4'd8) ? 3'd4 : 3'd1;
          end
          default: end_command();
        endcase
      end
      PH_WACK: begin
        case (bus_sub)
          3'd0: begin bus_sda_en = 1'b0; bus_scl = 1'b1; bus_delay = hold_ticks(1); bus_sub = 3'd1; end
          3'd1: begin
            bus_sda_en = 1'b0; bus_sda = 1'b1; bus_polls = '0;
            bus_delay = hold_ticks(1); bus_sub = 3'd2;
          end
          3'd2: begin
            // poll once per tick; timeout falls through into a stop
            if (!sda_in) begin
              bus_delay = hold_ticks(1); bus_sub = 3'd3;
            end else if (bus_polls == poll_limit) begin
              bus_fail = 1'b1; bus_phase = PH_STOP; bus_sub = '0; bus_delay = '0;
            end else begin
              bus_polls = bus_polls + 8'd1; bus_delay = '0;
            end
          end
          3'd3: begin
            bus_scl = 1'b0; bus_sda_en = 1'b1; bus_sda = 1'b0; bus_fail = 1'b0;
            bus_delay = hold_ticks(1); bus_sub = 3'd4;
          end
          default: end_command();
        endcase
      end
      PH_READ: begin
        case (bus_sub)
          3'd0: begin
            bus_sda_en = 1'b0; bus_sda = 1'b1; bus_scl = 1'b0;
            bus_bit = '0; bus_shift = '0; bus_delay = hold_ticks(0); bus_sub = 3'd1;
          end
          3'd1: begin bus_scl = 1'b0; bus_delay = hold_ticks(2); bus_sub = 3'd2; end
          3'd2: begin
            bus_scl   = 1'b1;
            bus_shift = {bus_shift[6:0], sda_in};
            bus_bit   = bus_bit + 4'd1;
            bus_delay = hold_ticks(1);
            bus_sub   = (bus_bit >= 4'd8) ? 3'd3 : 3'd1;
          end
          3'd3: begin
            bus_rx = bus_shift;
            bus_scl = 1'b0; bus_sda_en = 1'b1; bus_sda = !bus_ack;
            bus_delay = hold_ticks(2); bus_sub = 3'd4;
          end
          3'd4: begin bus_scl = 1'b1; bus_delay = hold_ticks(2); bus_sub = 3'd5; end
          default: begin bus_scl = 1'b0; end_command(); end
        endcase
      end
      default: end_command();
    endcase
  endfunction

  // one tick of the line model; returns the line state after it
  function automatic res_t bus_tick(input item_t it);
    res_t r;
    logic launch;
    bus_done = 1'b0;
    if (bus_phase == PH_IDLE) begin
      launch = 1'b1;
      case (it.opcode)
        OP_START: bus_phase = PH_START;
        OP_STOP:  bus_phase = PH_STOP;
        OP_SEND:  bus_phase = PH_SEND;
        OP_WACK:  bus_phase = PH_WACK;
        OP_READ:  bus_phase = PH_READ;
        default:  launch = 1'b0;
      endcase
      if (launch) begin
        bus_sub   = '0;
        bus_delay = '0;
        if (it.opcode == OP_SEND) bus_shift = it.tx_byte;
        if (it.opcode == OP_READ) bus_ack = it.send_ack;
        advance_step(it.sda_in);
      end
    end else if (bus_delay != '0) begin
      bus_delay = bus_delay - 14'd1;
    end else begin
      advance_step(it.sda_in);
    end
    r.scl_level  = bus_scl;
    r.sda_level  = bus_sda;
    r.sda_enable = bus_sda_en;
    r.busy_res   = (bus_phase != PH_IDLE);
    r.done_res   = bus_done;
    r.rx_byte    = bus_rx;
    r.ack_failed = bus_fail;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTED) $display("cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 'h%0h expected 'h%0h", name, got, want));
  endtask

  // compare every result transaction with the oldest prediction
  always @(posedge clk) begin : line_check
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_lines.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_lines.pop_front();
        check_field("scl_level", 8'(out_ch.scl_level), 8'(want.scl_level));
        check_field("sda_level", 8'(out_ch.sda_level), 8'(want.sda_level));
        check_field("sda_enable", 8'(out_ch.sda_enable), 8'(want.sda_enable));
        check_field("busy_res", 8'(out_ch.busy_res), 8'(want.busy_res));
        check_field("done_res", 8'(out_ch.done_res), 8'(want.done_res));
        check_field("rx_byte", out_ch.rx_byte, want.rx_byte);
        check_field("ack_failed", 8'(out_ch.ack_failed), 8'(want.ack_failed));
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[i2c_master_bit_engine] ERROR");
      $finish;
    end
  end

  // drive one tick transaction and predict its result once accepted
  task automatic send_tick(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= it.opcode;
    in_ch.tx_byte  <= it.tx_byte;
    in_ch.send_ack <= it.send_ack;
    in_ch.sda_in   <= it.sda_in;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_lines.push_back(bus_tick(it));
    ticks_sent++;
  endtask

  // issue a command, then keep ticking until the model says it is done;
  // ticks while busy carry random opcodes, which the engine must ignore
  task automatic run_command(input logic [2:0] op, input logic [7:0] data, input logic ack,
                             input int sda_fill, input int ack_wait);
    item_t it;
    int k = 0;
    it.opcode   = op;
    it.tx_byte  = data;
    it.send_ack = ack;
    do begin
      if (k > 0) begin
        it.opcode   = 3'($urandom_range(7));
        it.tx_byte  = 8'($urandom);
        it.send_ack = 1'($urandom);
      end
      if (op == OP_WACK) it.sda_in = (k < ack_wait);
      else if (sda_fill == SDA_LOW) it.sda_in = 1'b0;
      else if (sda_fill == SDA_HIGH) it.sda_in = 1'b1;
      else it.sda_in = 1'($urandom);
      send_tick(it);
      k++;
    end while (bus_phase != PH_IDLE);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TICKS_PER_US) tick_scale = val;
    else poll_limit = val[7:0];
  endtask

  // no-command opcodes while idle
  task automatic test_idle_codes();
    run_command(OP_NONE, 8'hFF, 1'b1, SDA_HIGH, 0);
    run_command(OP_SPARE6, 8'h00, 1'b0, SDA_LOW, 0);
    run_command(OP_SPARE7, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
  endtask

  task automatic test_start_stop();
    run_command(OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
    run_command(OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
  endtask

  // extreme bytes out, ack on the first poll and after a few high polls
  task automatic test_send_bytes();
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(OP_SEND, 8'hFF, 1'b0, SDA_RANDOM, 0);
    run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(OP_SEND, 8'h00, 1'b1, SDA_RANDOM, 0);
    run_command(OP_WACK, 8'hFF, 1'b1, SDA_RANDOM, 5);
    run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  // all-ones and all-zero bytes in, both answers
  task automatic test_read_bytes();
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(OP_READ, 8'h00, 1'b1, SDA_HIGH, 0);
    run_command(OP_READ, 8'hFF, 1'b0, SDA_LOW, 0);
    run_command(OP_READ, 8'($urandom), 1'b1, SDA_RANDOM, 0);
    run_command(OP_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  // zero timeout, longest timeout, ack on the last poll and one poll late
  task automatic test_ack_timeout();
    write_reg(CFG_ACK_TIMEOUT, 10'd0);
    run_command(OP_START, 8'h00, 1'b0, SDA_RANDOM, 0);
    run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM, NO_ACK);
    write_reg(CFG_ACK_TIMEOUT, 10'd255);
    run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM, NO_ACK);
    write_reg(CFG_ACK_TIMEOUT, 10'd3);
    run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM, 5);
    run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM, 6);
    run_command(OP_WACK, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  // zero scale counts as one, then a larger scale
  task automatic test_delay_scaling();
    write_reg(CFG_TICKS_PER_US, 10'd0);
    test_start_stop();
    write_reg(CFG_TICKS_PER_US, 10'd6);
    test_start_stop();
    write_reg(CFG_TICKS_PER_US, 10'd2);
    run_command(OP_READ, 8'h00, 1'b0, SDA_RANDOM, 0);
  endtask

  // one bus transaction, mostly well formed, sometimes a stray command
  task automatic random_transaction();
    int nbytes;
    if ($urandom_range(99) < 20) begin
      run_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom), SDA_RANDOM,
                  $urandom_range(12));
      return;
    end
    if ($urandom_range(99) < 30) run_command(OP_NONE, 8'($urandom), 1'b0, SDA_RANDOM, 0);
    run_command(OP_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
    run_command(OP_SEND, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
    run_command(OP_WACK, 8'($urandom), 1'($urandom), SDA_RANDOM,
                ($urandom_range(99) < 80) ? $urandom_range(8) : NO_ACK);
    // a timeout already put a stop on the bus
    if (bus_fail) return;
    nbytes = $urandom_range(1, 2);
    repeat (nbytes) begin
      if ($urandom_range(1)) begin
        run_command(OP_SEND, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
        run_command(OP_WACK, 8'($urandom), 1'($urandom), SDA_RANDOM, $urandom_range(8));
      end else begin
        run_command(OP_READ, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
      end
    end
    if ($urandom_range(99) < 90) run_command(OP_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
  endtask

  task automatic test_random_traffic(input int idle_in, input int idle_out,
                                     input logic [9:0] scale, input int budget);
    int first_tick;
    send_idle_pct = idle_in;
    recv_idle_pct = idle_out;
    write_reg(CFG_TICKS_PER_US, scale);
    write_reg(CFG_ACK_TIMEOUT, 10'($urandom_range(12)));
    first_tick = ticks_sent;
    random_transaction();
    // hold off until the engine has answered everything
    wait_drained();
    while (ticks_sent - first_tick < budget) random_transaction();
  endtask

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= CFG_TICKS_PER_US;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= OP_NONE;
    in_ch.tx_byte  <= '0;
    in_ch.send_ack <= 1'b0;
    in_ch.sda_in   <= 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 22;
    recv_idle_pct = 52;
    test_idle_codes();
    test_start_stop();
    test_send_bytes();
    test_read_bytes();
    test_ack_timeout();
    test_delay_scaling();

    test_random_traffic(22, 52, 10'($urandom_range(1, 2)), 60);
    test_random_traffic(52, 22, 10'($urandom_range(1, 2)), 60);
    test_random_traffic(0, 0, 10'd1, 30);

    wait_drained();
    if (mismatch_count == 0) begin
      $display("[i2c_master_bit_engine] OK");
    end else begin
      $display("[i2c_master_bit_engine] ERROR");
    end
    $finish;
  end

endmodule
